@@ rtl/core/frb_pkg.sv @@
package frb_pkg;
   localparam int IN_WIDTH  = 64;
   localparam int OUT_WIDTH = 32;
   localparam int CNT_WIDTH = $clog2(IN_WIDTH + 1);
   localparam logic [IN_WIDTH-1:0] BOUND_DEFAULT =
      (OUT_WIDTH >= IN_WIDTH) ? {IN_WIDTH{1'b1}}
                              : IN_WIDTH'({OUT_WIDTH{1'b1}});
   localparam int REQ_BITS = 3 * IN_WIDTH;
   localparam int REQ_TDATA_WIDTH = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS = 2 * OUT_WIDTH;
   localparam int RSP_TDATA_WIDTH = ((RSP_BITS + 7) / 8) * 8;
endpackage

@@ rtl/core/fraction_reduce_bounded_top.sv @@
// Bounded fraction reduction.
// req channel: one transaction carries numerator, denominator and term_bound.
// rsp channel: one transaction carries reduced_num, reduced_den; tuser is exact.
// A zero denominator gives 0/1 exact. Otherwise the fraction is reduced by
// its GCD and, if a term exceeds the bound (zero bound = all ones of the
// output width), replaced by the last continued-fraction convergent that fits.
// All division is done by one restoring divider, one quotient bit per cycle.
// Multiplications by the quotient are shift-and-add, one bit per cycle,
// running in step with each convergent division.
// Each GCD step is one division; both terms are then divided by the GCD, n
// first, then d; each convergent step is one division followed by a check.
// A zero denominator skips all division and goes straight to the result.
// One item is processed at a time; req_tready is high only while idle.
// The result is held in the output register until rsp_tready; a new request
// is accepted in the same cycle that the result is taken.
// Reset (synchronous, active high) drops any item in progress and the
// pending result.
module fraction_reduce_bounded_top (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // numerator [63:0], denominator [127:64], term_bound [191:128]
   input  logic [frb_pkg::REQ_TDATA_WIDTH-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // reduced_num [31:0], reduced_den [63:32]
   output logic [frb_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata,
   // exact [0]
   output logic rsp_tuser
);
   localparam int W  = frb_pkg::IN_WIDTH;
   localparam int OW = frb_pkg::OUT_WIDTH;
   localparam int CW = frb_pkg::CNT_WIDTH;

   typedef enum logic [2:0] {
      S_IDLE, S_GDIV, S_NORM, S_CDIV, S_CCHK, S_DONE
   } state_type;

   state_type state_ff;
   logic [W-1:0] b_ff, lim_ff, nn_ff, dd_ff;
   logic [W-1:0] rem_ff, quo_ff, dvd_ff;
   logic [W-1:0] p0_ff, q0_ff, p1_ff, q1_ff, pm_ff, qm_ff;
   logic [CW-1:0] cnt_ff;
   logic [1:0] phase_ff;
   logic [OW-1:0] rnum_ff, rden_ff;
   logic exact_ff, rvalid_ff;

   logic [W:0] trial;
   logic [W-1:0] rem_sh, rem_in, quo_in;
   logic qbit;
   logic [W-1:0] p2, q2;
   logic take;

   assign take  = rsp_tvalid && rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && (!rvalid_ff || rsp_tready);

   // restoring division step on the current divisor b_ff
   assign rem_sh = {rem_ff[W-2:0], dvd_ff[W-1]};
   assign trial  = {rem_ff, dvd_ff[W-1]} - {1'b0, b_ff};
   assign qbit   = !trial[W];
   assign rem_in = qbit ? trial[W-1:0] : rem_sh;
   assign quo_in = {quo_ff[W-2:0], qbit};
   assign p2 = pm_ff + p0_ff;
   assign q2 = qm_ff + q0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rvalid_ff <= 1'b0;
      end else begin
         if (take) rvalid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid && req_tready) begin
                  b_ff   <= req_tdata[2*W-1:W];
                  nn_ff  <= req_tdata[W-1:0];
                  dd_ff  <= req_tdata[2*W-1:W];
                  lim_ff <= (req_tdata[3*W-1:2*W] == '0) ? frb_pkg::BOUND_DEFAULT
                                                          : req_tdata[3*W-1:2*W];
                  if (req_tdata[2*W-1:W] == '0) begin
                     rnum_ff   <= '0;
                     rden_ff   <= OW'(1);
                     exact_ff  <= 1'b1;
                     state_ff  <= S_DONE;
                  end else begin
                     rem_ff   <= '0;
                     dvd_ff   <= req_tdata[W-1:0];
                     cnt_ff   <= '0;
                     state_ff <= S_GDIV;
                  end
               end
            end
            S_GDIV: begin
               // a mod b, one bit per cycle
               if (cnt_ff == CW'(W - 1)) begin
                  rem_ff <= '0;
                  cnt_ff <= '0;
                  if (rem_in == '0) begin
                     // b is the gcd: divide n then d by it
                     phase_ff <= 2'd0;
                     dvd_ff   <= nn_ff;
                     state_ff <= S_NORM;
                  end else begin
                     b_ff   <= rem_in;
                     dvd_ff <= b_ff;
                  end
               end else begin
                  rem_ff <= rem_in;
                  dvd_ff <= {dvd_ff[W-2:0], 1'b0};
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            S_NORM: begin
               quo_ff <= quo_in;
               if (cnt_ff == CW'(W - 1)) begin
                  rem_ff <= '0;
                  cnt_ff <= '0;
                  if (phase_ff == 2'd0) begin
                     nn_ff    <= quo_in;
                     dvd_ff   <= dd_ff;
                     phase_ff <= 2'd1;
                  end else begin
                     dd_ff <= quo_in;
                     if (nn_ff > lim_ff || quo_in > lim_ff) begin
                        b_ff   <= quo_in;
                        dvd_ff <= nn_ff;
                        p0_ff <= '0; q0_ff <= W'(1);
                        p1_ff <= W'(1); q1_ff <= '0;
                        pm_ff <= '0; qm_ff <= '0;
                        state_ff <= S_CDIV;
                     end else begin
                        rnum_ff  <= OW'(nn_ff);
                        rden_ff  <= OW'(quo_in);
                        exact_ff <= 1'b1;
                        state_ff <= S_DONE;
                     end
                  end
               end else begin
                  rem_ff <= rem_in;
                  dvd_ff <= {dvd_ff[W-2:0], 1'b0};
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            S_CDIV: begin
               // n / d with quotient bits fed MSB first into x*p1, x*q1
               rem_ff <= rem_in;
               dvd_ff <= {dvd_ff[W-2:0], 1'b0};
               pm_ff  <= {pm_ff[W-2:0], 1'b0} + (qbit ? p1_ff : '0);
               qm_ff  <= {qm_ff[W-2:0], 1'b0} + (qbit ? q1_ff : '0);
               if (cnt_ff == CW'(W - 1)) state_ff <= S_CCHK;
               else cnt_ff <= cnt_ff + 1'b1;
            end
            S_CCHK: begin
               if (p2 > lim_ff || q2 > lim_ff || rem_ff == '0) begin
                  if (p2 > lim_ff || q2 > lim_ff) begin
                     rnum_ff <= OW'(p1_ff);
                     rden_ff <= OW'(q1_ff);
                  end else begin
                     rnum_ff <= OW'(p2);
                     rden_ff <= OW'(q2);
                  end
                  exact_ff <= 1'b0;
                  state_ff <= S_DONE;
               end else begin
                  p0_ff <= p1_ff; q0_ff <= q1_ff;
                  p1_ff <= p2;    q1_ff <= q2;
                  pm_ff <= '0;    qm_ff <= '0;
                  dvd_ff <= b_ff;
                  b_ff   <= rem_ff;
                  rem_ff <= '0;
                  cnt_ff <= '0;
                  state_ff <= S_CDIV;
               end
            end
            S_DONE: begin
               // the output register is empty here, since requests wait for it
               if (!rvalid_ff) begin
                  rvalid_ff <= 1'b1;
                  state_ff  <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = frb_pkg::RSP_TDATA_WIDTH'({rden_ff, rnum_ff});
   assign rsp_tuser  = exact_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_tready)
      else $error("request accepted while busy");
   a_div_nz: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_GDIV || state_ff == S_NORM || state_ff == S_CDIV) |-> b_ff != '0
      || state_ff == S_NORM)
      else $error("division by zero");
   a_exact_zero: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) && rsp_tuser |-> rsp_tdata[OW-1:0] <= lim_ff
      || rsp_tdata[2*OW-1:OW] == OW'(1))
      else $error("exact result above bound");
endmodule

@@ sim/fraction_reduce_checker.sv @@
`timescale 1ns / 100ps
module fraction_reduce_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   input  logic req_tready,
   input  logic [frb_pkg::REQ_TDATA_WIDTH-1:0] req_tdata,
   input  logic rsp_tvalid,
   input  logic rsp_tready,
   input  logic [frb_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata,
   input  logic rsp_tuser,
   output int   fail_count,
   output int   pending_count
);
   localparam int IW = frb_pkg::IN_WIDTH;
   localparam int OW = frb_pkg::OUT_WIDTH;

   typedef struct packed {
      logic          exact;
      logic [OW-1:0] den;
      logic [OW-1:0] num;
   } ratio_type;

   ratio_type expected_ratios[$];

   function automatic ratio_type approximate_ratio(logic [IW-1:0] n_in,
                                                   logic [IW-1:0] d_in,
                                                   logic [IW-1:0] b_in);
      logic [IW-1:0] n, d, bound, a, b, r, quot, p0, q0, p1, q1, p2, q2;
      ratio_type res;
      n = n_in;
      d = d_in;
      bound = b_in;
      res.exact = 1'b1;
      if (d == '0) begin
         res.num = '0;
         res.den = OW'(1);
         return res;
      end
      a = n;
      b = d;
      while (b != '0) begin
         r = a % b;
         a = b;
         b = r;
      end
      n = n / a;
      d = d / a;
      if (bound == '0) bound = frb_pkg::BOUND_DEFAULT;
      if (n > bound || d > bound) begin
         res.exact = 1'b0;
         p0 = '0; q0 = IW'(1); p1 = IW'(1); q1 = '0;
         forever begin
            quot = n / d;
            p2 = quot * p1 + p0;
            q2 = quot * q1 + q0;
            if (p2 > bound || q2 > bound) break;
            n = n % d;
            p0 = p1; q0 = q1;
            p1 = p2; q1 = q2;
            if (n == '0) break;
            r = n; n = d; d = r;
         end
         n = p1;
         d = q1;
      end
      res.num = n[OW-1:0];
      res.den = d[OW-1:0];
      return res;
   endfunction

   assign pending_count = expected_ratios.size();

   always @(posedge clock) begin
      ratio_type want, got;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_tvalid && req_tready)
            expected_ratios.push_back(approximate_ratio(req_tdata[IW-1:0],
               req_tdata[2*IW-1:IW], req_tdata[3*IW-1:2*IW]));
         if (rsp_tvalid && rsp_tready) begin
            got.num = rsp_tdata[OW-1:0];
            got.den = rsp_tdata[2*OW-1:OW];
            got.exact = rsp_tuser;
            if (expected_ratios.size() == 0) begin
               $display("%0t unexpected transaction: expected none, actual %h/%h exact %b",
                  $time, got.num, got.den, got.exact);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_ratios.pop_front();
               if (got != want) begin
                  $display("%0t mismatch: expected %h/%h exact %b, actual %h/%h exact %b",
                     $time, want.num, want.den, want.exact, got.num, got.den, got.exact);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

@@ sim/tb_fraction_reduce_bounded_top.sv @@
`timescale 1ns / 100ps
module tb_fraction_reduce_bounded_top;
   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [frb_pkg::REQ_TDATA_WIDTH-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [frb_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata;
   logic rsp_tuser;
   int fail_count, pending_count;
   int cycle_count = 0;
   int stall_left = 0;
   localparam int CYCLE_LIMIT = 20000000;

   always #1 clock = ~clock;

   fraction_reduce_bounded_top dut (.*);
   fraction_reduce_checker checker_i (.*);

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic int gap_len();
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
      return $urandom_range(0, 2);
   endfunction

   // random value with at most nbits significant bits
   function automatic logic [63:0] rand_bits(int nbits);
      logic [63:0] v;
      v = rand64();
      if (nbits < 64) v = v & ((64'd1 << nbits) - 64'd1);
      return v;
   endfunction

   task automatic send_fraction(logic [63:0] n, logic [63:0] d, logic [63:0] b);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {b, d, n};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // receiver stalls: short mostly, some long, stretches with none
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (cycle_count % 3000 < 600) begin
         rsp_tready <= 1'b1;
      end else if ($urandom_range(0, 49) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(10, 60);
      end else begin
         rsp_tready <= ($urandom_range(0, 19) != 0) && ($urandom_range(0, 3) != 0);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      logic [63:0] n, d, b, g;
      int sel;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: zero denominator, zero numerator, extremes, first quotient too big
      send_fraction('1, 64'd0, 64'd0);
      send_fraction(64'd0, 64'd0, 64'd5);
      send_fraction(64'd0, 64'd12345, 64'd0);
      send_fraction('1, '1, 64'd0);
      send_fraction('1, 64'd1, 64'd0);
      send_fraction(64'd1, '1, 64'd0);
      send_fraction('1, 64'd1, 64'd10);
      send_fraction(64'd1, '1, 64'd10);
      send_fraction(64'hFFFFFFFF, 64'd1, 64'd0);
      send_fraction(64'h1_0000_0000, 64'd1, 64'd0);
      send_fraction(64'd6, 64'd4, 64'd1);
      send_fraction(64'd355000, 64'd113000, 64'd0);
      send_fraction(64'hC90FDAA22168C234, 64'h4000000000000000, 64'd1000);
      send_fraction('1, 64'hFFFFFFFFFFFFFFFE, 64'd0);
      send_fraction('1, 64'h8000000000000001, '1);
      send_fraction(64'hDEADBEEFCAFEF00D, 64'h123456789ABCDEF1, 64'h8000000000000000);
      send_fraction(64'h9E3779B97F4A7C15, 64'h5851F42D4C957F2D, 64'h1_0000_0000_0000);
      send_fraction(64'd1920, 64'd1080, 64'd0);
      req_tvalid <= 1'b0;
      @(posedge clock);
      // hold off until every result has come
      while (pending_count != 0) @(posedge clock);
      for (int i = 0; i < 122; i++) begin
         sel = $urandom_range(0, 9);
         n = rand_bits($urandom_range(0, 64));
         d = rand_bits($urandom_range(0, 64));
         b = (sel < 3) ? 64'd0 : rand_bits($urandom_range(1, 64));
         if (sel == 9) begin
            // common factor
            g = rand_bits($urandom_range(1, 20));
            n = rand_bits(40) * g;
            d = rand_bits(40) * g;
         end else if (sel == 8) begin
            d = 64'd0;
         end
         send_fraction(n, d, b);
      end
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end
endmodule
